// ===== rtl/mrm_pkg.sv =====
// Package for the 4x4 row multiply unit: sizes, operation codes and data types.
// Used by every module of the unit; depends on nothing else.
package mrm_pkg;

   localparam int DIM         = 4;
   localparam int ELEM_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int FIELD_WIDTH = 32;
   localparam int ROW_FIELDS  = 4;
   localparam int ROW_IDX_W   = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int REQ_ROW_W   = 2;
   localparam int NCOL        = (DIM < ROW_FIELDS) ? DIM : ROW_FIELDS;
   localparam int PROD_W      = 2 * ELEM_WIDTH;
   localparam int SUM_W       = PROD_W + $clog2(DIM);

   typedef enum logic {
      OP_LOAD     = 1'b0,
      OP_MULTIPLY = 1'b1
   } op_type;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;

   typedef elem_type row_type [DIM];
   typedef row_type  matrix_type [DIM];
   typedef sum_type  sum_row_type [NCOL];

   typedef struct packed {
      logic                 en;
      logic [ROW_IDX_W-1:0] row;
   } store_write_type;

   typedef struct packed {
      logic in_valid;
      logic out_free;
   } dot_ctrl_type;

   typedef struct packed {
      logic in_free;
      logic sum_valid;
   } dot_status_type;

endpackage

// ===== rtl/matrix4_row_multiply_unit.sv =====
// Top level of the row multiply unit: input register, stored matrix, dot pipeline
// and the saturating result register. Depends on mrm_pkg, mrm_row_store, mrm_dot_pipe.
// A multiply beat passes the input register, the product and sum stages and the result register to rsp_valid.
// Throughput: one beat per cycle while req_stall is low; loads and multiplies may follow each other freely.
// A load beat writes its row as it leaves the input register and gives no result.
// Reset clears the stored matrix to zero and empties every pipeline stage.
module matrix4_row_multiply_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_op,
   input  logic [mrm_pkg::REQ_ROW_W-1:0]       req_row_index,
   input  logic signed [mrm_pkg::FIELD_WIDTH-1:0] req_elem0,
   input  logic signed [mrm_pkg::FIELD_WIDTH-1:0] req_elem1,
   input  logic signed [mrm_pkg::FIELD_WIDTH-1:0] req_elem2,
   input  logic signed [mrm_pkg::FIELD_WIDTH-1:0] req_elem3,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [mrm_pkg::FIELD_WIDTH-1:0] rsp_prod0,
   output logic signed [mrm_pkg::FIELD_WIDTH-1:0] rsp_prod1,
   output logic signed [mrm_pkg::FIELD_WIDTH-1:0] rsp_prod2,
   output logic signed [mrm_pkg::FIELD_WIDTH-1:0] rsp_prod3,
   output logic                                rsp_saturated
);
   import mrm_pkg::*;

   typedef struct packed {
      elem_type value;
      logic     clip;
   } sat_type;

   function automatic sat_type saturate(input sum_type sum);
      sum_type                    shifted;
      logic [SUM_W-ELEM_WIDTH:0]  top_bits;
      sat_type                    r;
      shifted  = sum >>> FRAC_BITS;
      top_bits = shifted[SUM_W-1:ELEM_WIDTH-1];
      if (top_bits == '0 || top_bits == '1) begin
         r.value = shifted[ELEM_WIDTH-1:0];
         r.clip  = 1'b0;
      end else begin
         r.clip  = 1'b1;
         r.value = shifted[SUM_W-1] ? {1'b1, {(ELEM_WIDTH-1){1'b0}}}
                                    : {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

   logic [FIELD_WIDTH-1:0] req_field [ROW_FIELDS];

   logic                 in_valid_ff;
   logic                 in_valid_in;
   logic                 in_op_ff;
   logic [REQ_ROW_W-1:0] in_row_ff;
   row_type              in_data_ff;
   row_type              in_data_in;
   logic                 in_adv;
   logic                 in_load;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [FIELD_WIDTH-1:0] out_prod_ff [ROW_FIELDS];
   logic [FIELD_WIDTH-1:0] out_prod_in [ROW_FIELDS];
   logic                   out_sat_ff;
   logic                   out_sat_in;
   logic                   out_free;

   store_write_type wr;
   matrix_type      matrix;
   dot_ctrl_type    dot_ctrl;
   dot_status_type  dot_status;
   sum_row_type     sums;
   sat_type         col_sat;

   assign req_field[0] = req_elem0;
   assign req_field[1] = req_elem1;
   assign req_field[2] = req_elem2;
   assign req_field[3] = req_elem3;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign in_load   = (in_op_ff != OP_MULTIPLY);
   assign in_adv    = in_valid_ff && (in_load || dot_status.in_free);
   assign req_stall = in_valid_ff && !in_adv;

   always_comb begin
      for (int j = 0; j < DIM; j++) begin
         in_data_in[j] = '0;
      end
      for (int j = 0; j < NCOL; j++) begin
         in_data_in[j] = req_field[j][ELEM_WIDTH-1:0];
      end
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_op_ff   <= req_op;
         in_row_ff  <= req_row_index;
         in_data_ff <= in_data_in;
      end
   end

   assign wr.en  = in_valid_ff && in_load && (int'(in_row_ff) < DIM);
   assign wr.row = ROW_IDX_W'(in_row_ff);

   mrm_row_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .wr_data (in_data_ff),
      .matrix  (matrix)
   );

   assign dot_ctrl.in_valid = in_valid_ff && !in_load;
   assign dot_ctrl.out_free = out_free;

   mrm_dot_pipe u_dot (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (dot_ctrl),
      .row    (in_data_ff),
      .matrix (matrix),
      .status (dot_status),
      .sums   (sums)
   );

   always_comb begin
      out_sat_in = 1'b0;
      col_sat    = '0;
      for (int j = 0; j < ROW_FIELDS; j++) begin
         out_prod_in[j] = '0;
      end
      for (int j = 0; j < NCOL; j++) begin
         col_sat        = saturate(sums[j]);
         out_prod_in[j] = FIELD_WIDTH'(unsigned'(col_sat.value));
         out_sat_in     = out_sat_in | col_sat.clip;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = dot_status.sum_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && dot_status.sum_valid) begin
         out_prod_ff <= out_prod_in;
         out_sat_ff  <= out_sat_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_prod0     = out_prod_ff[0];
   assign rsp_prod1     = out_prod_ff[1];
   assign rsp_prod2     = out_prod_ff[2];
   assign rsp_prod3     = out_prod_ff[3];
   assign rsp_saturated = out_sat_ff;

endmodule

// ===== rtl/mrm_row_store.sv =====
// Register table that holds the right-hand matrix, written one row per load beat.
// Depends on mrm_pkg for sizes and types.
module mrm_row_store (
   input  logic                    clock,
   input  logic                    reset,
   input  mrm_pkg::store_write_type wr,
   input  mrm_pkg::row_type         wr_data,
   output mrm_pkg::matrix_type      matrix
);
   import mrm_pkg::*;

   matrix_type matrix_ff;
   matrix_type matrix_in;

   always_comb begin
      matrix_in = matrix_ff;
      if (wr.en) begin
         matrix_in[wr.row] = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
               matrix_ff[r][c] <= '0;
            end
         end
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   assign matrix = matrix_ff;

endmodule

// ===== rtl/mrm_dot_pipe.sv =====
// Two-stage dot product pipeline: a product register stage and a column sum stage.
// Depends on mrm_pkg for sizes, types and the control structs.
module mrm_dot_pipe (
   input  logic                    clock,
   input  logic                    reset,
   input  mrm_pkg::dot_ctrl_type   ctrl,
   input  mrm_pkg::row_type        row,
   input  mrm_pkg::matrix_type     matrix,
   output mrm_pkg::dot_status_type status,
   output mrm_pkg::sum_row_type    sums
);
   import mrm_pkg::*;

   prod_type    prod_ff [NCOL][DIM];
   prod_type    prod_in [NCOL][DIM];
   sum_row_type sum_ff;
   sum_row_type sum_in;
   logic        prod_valid_ff;
   logic        prod_valid_in;
   logic        sum_valid_ff;
   logic        sum_valid_in;
   logic        sum_adv;
   logic        prod_adv;
   logic        in_free;

   assign sum_adv  = sum_valid_ff && ctrl.out_free;
   assign prod_adv = prod_valid_ff && (!sum_valid_ff || sum_adv);
   assign in_free  = !prod_valid_ff || prod_adv;

   always_comb begin
      for (int c = 0; c < NCOL; c++) begin
         for (int k = 0; k < DIM; k++) begin
            prod_in[c][k] = PROD_W'($signed(row[k]) * $signed(matrix[k][c]));
         end
      end
      for (int c = 0; c < NCOL; c++) begin
         sum_in[c] = '0;
         for (int k = 0; k < DIM; k++) begin
            sum_in[c] = sum_in[c] + SUM_W'(prod_ff[c][k]);
         end
      end
      prod_valid_in = prod_valid_ff;
      if (in_free) begin
         prod_valid_in = ctrl.in_valid;
      end
      sum_valid_in = sum_valid_ff;
      if (!sum_valid_ff || sum_adv) begin
         sum_valid_in = prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_free && ctrl.in_valid) begin
         prod_ff <= prod_in;
      end
      if (prod_adv) begin
         sum_ff <= sum_in;
      end
   end

   assign status.in_free   = in_free;
   assign status.sum_valid = sum_valid_ff;
   assign sums             = sum_ff;

endmodule

// ===== verif/matrix4_row_multiply_unit_tb.sv =====
// Self-checking testbench for matrix4_row_multiply_unit: loads rows of the stored matrix,
// streams multiply rows with random idle and stall, and checks each result row in order.
// Depends on mrm_pkg and the matrix4_row_multiply_unit RTL.
`timescale 1ns / 100ps

module matrix4_row_multiply_unit_tb;
   import mrm_pkg::*;

   localparam int RANDOM_BEATS = 2000;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SHOWN_ERRORS = 10;

   typedef elem_type four_elems_type [DIM];

   typedef struct {
      four_elems_type prod;
      logic           saturated;
   } result_row_type;

   class row_product_scoreboard_type;
      elem_type       right_rows [DIM][DIM];
      result_row_type expected_rows [$];
      int             mismatches;

      function new();
         foreach (right_rows[r, c]) right_rows[r][c] = '0;
         mismatches = 0;
      endfunction

      // Each column is the exact sum of four products, floored by the fraction bits
      // and clipped to the element range.
      function result_row_type row_times_matrix(four_elems_type a_row);
         localparam logic signed [71:0] SAT_MAX = 72'sd2147483647;
         localparam logic signed [71:0] SAT_MIN = -72'sd2147483648;
         result_row_type     res;
         logic signed [71:0] acc;
         logic signed [71:0] scaled;
         longint             term;
         int                 c;
         int                 k;
         res.saturated = 1'b0;
         for (c = 0; c < DIM; c++) begin
            acc = '0;
            for (k = 0; k < DIM; k++) begin
               term = longint'(a_row[k]) * longint'(right_rows[k][c]);
               acc  = acc + {{8{term[63]}}, term};
            end
            scaled = acc >>> FRAC_BITS;
            if (scaled > SAT_MAX) begin
               res.prod[c]   = SAT_MAX[31:0];
               res.saturated = 1'b1;
            end else if (scaled < SAT_MIN) begin
               res.prod[c]   = SAT_MIN[31:0];
               res.saturated = 1'b1;
            end else begin
               res.prod[c] = scaled[31:0];
            end
         end
         return res;
      endfunction

      function void note_request(logic op, logic [1:0] row, four_elems_type elems);
         if (op == OP_LOAD) begin
            if (int'(row) < DIM) right_rows[row] = elems;
         end else begin
            expected_rows.push_back(row_times_matrix(elems));
         end
      endfunction

      function void flag(string what);
         if (mismatches < SHOWN_ERRORS) $display("mismatch: %s", what);
         mismatches++;
      endfunction

      function void check_response(four_elems_type got, logic got_sat);
         result_row_type want;
         int             c;
         if (expected_rows.size() == 0) begin
            flag("result beat with no multiply outstanding");
            return;
         end
         want = expected_rows.pop_front();
         for (c = 0; c < DIM; c++) begin
            if (got[c] !== want.prod[c])
               flag($sformatf("prod%0d expected %h actual %h", c, want.prod[c], got[c]));
         end
         if (got_sat !== want.saturated)
            flag($sformatf("saturated expected %b actual %b", want.saturated, got_sat));
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_op = OP_LOAD;
   logic [REQ_ROW_W-1:0]        req_row_index = '0;
   logic signed [FIELD_WIDTH-1:0] req_elem0 = '0;
   logic signed [FIELD_WIDTH-1:0] req_elem1 = '0;
   logic signed [FIELD_WIDTH-1:0] req_elem2 = '0;
   logic signed [FIELD_WIDTH-1:0] req_elem3 = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [FIELD_WIDTH-1:0] rsp_prod0;
   logic signed [FIELD_WIDTH-1:0] rsp_prod1;
   logic signed [FIELD_WIDTH-1:0] rsp_prod2;
   logic signed [FIELD_WIDTH-1:0] rsp_prod3;
   logic                        rsp_saturated;

   row_product_scoreboard_type sb;
   bit                         calm = 1'b1;
   int                         rsp_wait = 0;
   int                         cycles = 0;

   matrix4_row_multiply_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_row_index (req_row_index),
      .req_elem0     (req_elem0),
      .req_elem1     (req_elem1),
      .req_elem2     (req_elem2),
      .req_elem3     (req_elem3),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_prod0     (rsp_prod0),
      .rsp_prod1     (rsp_prod1),
      .rsp_prod2     (rsp_prod2),
      .rsp_prod3     (rsp_prod3),
      .rsp_saturated (rsp_saturated)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_op, req_row_index,
                         '{req_elem0, req_elem1, req_elem2, req_elem3});
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_response('{rsp_prod0, rsp_prod1, rsp_prod2, rsp_prod3}, rsp_saturated);
            rsp_wait = calm ? 0 : $urandom_range(0, 8);
         end
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_row(input logic op, input logic [1:0] row, input four_elems_type elems);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_row_index <= row;
      req_elem0     <= elems[0];
      req_elem1     <= elems[1];
      req_elem2     <= elems[2];
      req_elem3     <= elems[3];
      do @(posedge clock); while (req_stall);
   endtask

   function automatic elem_type rand_elem();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               4: return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
         1, 2, 3: return $urandom();
         default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   initial begin
      four_elems_type elems;
      int             r;
      int             n;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // A multiply before any load sees the cleared table.
      send_row(OP_MULTIPLY, 2'd0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1});

      for (r = 0; r < DIM; r++) begin
         elems    = '{default: '0};
         elems[r] = 32'h0001_0000;
         send_row(OP_LOAD, r[1:0], elems);
      end
      send_row(OP_MULTIPLY, 2'd3, '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1});

      // Full-scale entries drive both saturation directions.
      for (r = 0; r < DIM; r++)
         send_row(OP_LOAD, r[1:0], '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
      send_row(OP_MULTIPLY, 2'd1, '{default: 32'h7FFF_FFFF});
      send_row(OP_MULTIPLY, 2'd2, '{default: 32'h8000_0000});
      send_row(OP_MULTIPLY, 2'd0,
               '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});

      // A half-scale diagonal shows that negative halves round down.
      for (r = 0; r < DIM; r++) begin
         elems    = '{default: '0};
         elems[r] = 32'h0000_8000;
         send_row(OP_LOAD, r[1:0], elems);
      end
      send_row(OP_MULTIPLY, 2'd2, '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFD, 32'h8000_0001});

      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 200 == 0) calm = ($urandom_range(0, 3) == 0);
         for (r = 0; r < DIM; r++) elems[r] = rand_elem();
         if ($urandom_range(0, 3) == 0)
            send_row(OP_LOAD, 2'($urandom_range(0, 3)), elems);
         else
            send_row(OP_MULTIPLY, 2'($urandom_range(0, 3)), elems);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // The last accepted beat is noted at the same edge; let that settle first.
      @(posedge clock);
      while (sb.expected_rows.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (sb.mismatches == 0 && sb.expected_rows.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mrm_pkg.sv
rtl/mrm_row_store.sv
rtl/mrm_dot_pipe.sv
rtl/matrix4_row_multiply_unit.sv
verif/matrix4_row_multiply_unit_tb.sv
